// ----- hdl/pvd_pkg.sv -----
// Shared types and constants for the phenome vector distance block.
package pvd_pkg;

    localparam int DATA_W   = 16;
    localparam int DIFF_W   = 18;
    localparam int MAG_W    = 17;
    localparam int SQ_W     = 34;
    localparam int SUM_W    = 46;
    localparam int ROOT_W   = 23;
    localparam int PAIR_W   = 24;
    localparam int DIST_W   = 22;
    localparam int SEL_W    = 3;
    localparam int NUM_SUMS = 5;
    localparam int ISQ_CNT_W = 5;

    localparam logic [ISQ_CNT_W-1:0] ISQ_LAST_STEP = 5'd22;

    // running sum selectors
    localparam logic [SEL_W-1:0] SEL_PAR_FIRST  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_PAR_SECOND = 3'd1;
    localparam logic [SEL_W-1:0] SEL_CRS_FIRST  = 3'd2;
    localparam logic [SEL_W-1:0] SEL_CRS_SECOND = 3'd3;
    localparam logic [SEL_W-1:0] SEL_MEAN_DIFF  = 3'd4;

    localparam logic [1:0] METHOD_HAPLOID = 2'd0;
    localparam logic [1:0] METHOD_MEAN    = 2'd1;
    localparam logic [1:0] METHOD_CROSS   = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

    typedef struct packed {
        logic             load;
        logic             sq_en;
        logic             acc_en;
        logic             clear;
        logic [SEL_W-1:0] sel;
    } acc_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } isq_stat_t;

endpackage

// ----- hdl/pvd_accum.sv -----
// Operand latch, shared squarer and the five saturating running sums.
module pvd_accum
    import pvd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  acc_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] first_a,
    input  logic signed [DATA_W-1:0] first_b,
    input  logic signed [DATA_W-1:0] second_a,
    input  logic signed [DATA_W-1:0] second_b,
    output logic [SUM_W-1:0]         sel_sum
);

    logic signed [DATA_W-1:0] fa_reg, fb_reg, sa_reg, sb_reg;
    logic signed [DIFF_W-1:0] fa_x, fb_x, sa_x, sb_x;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] diff_neg;
    logic [MAG_W-1:0]         mag;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [SUM_W:0]           sum_ext;
    logic [SUM_W-1:0]         sum_sat;
    logic [SUM_W-1:0]         sums_reg [NUM_SUMS];

    assign fa_x = DIFF_W'(fa_reg);
    assign fb_x = DIFF_W'(fb_reg);
    assign sa_x = DIFF_W'(sa_reg);
    assign sb_x = DIFF_W'(sb_reg);

    always_comb
    begin
        case (ctrl.sel)
            SEL_PAR_FIRST:  diff = fa_x - sa_x;
            SEL_PAR_SECOND: diff = fb_x - sb_x;
            SEL_CRS_FIRST:  diff = fb_x - sa_x;
            SEL_CRS_SECOND: diff = fa_x - sb_x;
            SEL_MEAN_DIFF:  diff = (fa_x + fb_x) - (sa_x + sb_x);
            default:        diff = '0;
        endcase
    end

    assign diff_neg = -diff;
    assign mag      = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    assign sq_next  = SQ_W'(mag) * SQ_W'(mag);

    always_comb
    begin
        if (ctrl.sel <= SEL_MEAN_DIFF)
        begin
            sel_sum = sums_reg[ctrl.sel];
        end
        else
        begin
            sel_sum = '0;
        end
    end

    // square is below 2^46, so one carry bit past the sum flags saturation
    assign sum_ext = {1'b0, sel_sum} + (SUM_W + 1)'(sq_reg);
    assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            fa_reg <= first_a;
            fb_reg <= first_b;
            sa_reg <= second_a;
            sb_reg <= second_b;
        end
        if (ctrl.sq_en)
        begin
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SUMS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < NUM_SUMS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (ctrl.acc_en)
        begin
            for (int i = 0; i < NUM_SUMS; i++)
            begin
                if (ctrl.sel == SEL_W'(i))
                begin
                    sums_reg[i] <= sum_sat;
                end
            end
        end
    end

endmodule

// ----- hdl/pvd_isqrt.sv -----
// Iterative floored integer square root, one result bit per cycle.
module pvd_isqrt
    import pvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  radicand,
    output isq_stat_t         stat,
    output logic [ROOT_W-1:0] root
);

    logic [SUM_W-1:0]     rad_reg;
    logic [PAIR_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [ISQ_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [PAIR_W+1:0]    rem_sh;
    logic [PAIR_W+1:0]    trial;
    logic [PAIR_W+1:0]    rem_sub;
    logic                 take;

    assign rem_sh  = {rem_reg, rad_reg[SUM_W-1:SUM_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign take    = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= take ? rem_sub[PAIR_W-1:0] : rem_sh[PAIR_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ISQ_LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ----- hdl/phenome_vector_distance.sv -----
// Top level: sequencer, method register, root combining and output register.
// Each locus is accepted and then takes five square/accumulate pairs.
// A final locus then runs one square root for methods 0, 1 and 3 and four
// for method 2, all on the one shared root unit, before the output register.
// A new locus is taken only once the last one is through (ready only in idle).
// Reset: rst_n asynchronous, clears sums, method (haploid) and control state.
module phenome_vector_distance
    import pvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,     // method
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // first_a, first_b, second_a, second_b
    input  logic        s_axis_tlast,    // final_locus
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // distance, zero fill
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SQ       = 3'd1;
    localparam logic [2:0] ST_ACC      = 3'd2;
    localparam logic [2:0] ST_RT_START = 3'd3;
    localparam logic [2:0] ST_RT_WAIT  = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;
    logic              last_reg, last_next;
    logic [1:0]        method_reg;
    logic [PAIR_W-1:0] par_reg, par_next;
    logic [PAIR_W-1:0] crs_reg, crs_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              in_fire;
    logic              out_free;
    logic              isq_start;
    acc_ctrl_t         acc_ctrl;
    isq_stat_t         isq_stat;
    logic [SUM_W-1:0]  sel_sum;
    logic [ROOT_W-1:0] root;
    logic [PAIR_W-1:0] d_full;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    pvd_accum u_accum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (acc_ctrl),
        .first_a  (s_axis_tdata[15:0]),
        .first_b  (s_axis_tdata[31:16]),
        .second_a (s_axis_tdata[47:32]),
        .second_b (s_axis_tdata[63:48]),
        .sel_sum  (sel_sum)
    );

    pvd_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (isq_start),
        .radicand (sel_sum),
        .stat     (isq_stat),
        .root     (root)
    );

    // method 1 keeps the root of the doubled mean difference in par
    always_comb
    begin
        case (method_reg)
            METHOD_MEAN:  d_full = par_reg >> 1;
            METHOD_CROSS: d_full = (par_reg < crs_reg) ? par_reg : crs_reg;
            default:      d_full = par_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        last_next      = last_reg;
        par_next       = par_reg;
        crs_next       = crs_reg;
        out_valid_next = out_valid_reg;
        dist_next      = dist_reg;
        isq_start      = 1'b0;
        acc_ctrl       = '{load: 1'b0, sq_en: 1'b0, acc_en: 1'b0, clear: 1'b0, sel: sel_reg};

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    acc_ctrl.load = 1'b1;
                    last_next     = s_axis_tlast;
                    sel_next      = SEL_PAR_FIRST;
                    state_next    = ST_SQ;
                end
            end
            ST_SQ:
            begin
                acc_ctrl.sq_en = 1'b1;
                state_next     = ST_ACC;
            end
            ST_ACC:
            begin
                acc_ctrl.acc_en = 1'b1;
                if (sel_reg == SEL_MEAN_DIFF)
                begin
                    par_next = '0;
                    crs_next = '0;
                    if (last_reg)
                    begin
                        sel_next   = (method_reg == METHOD_MEAN) ? SEL_MEAN_DIFF
                                                                 : SEL_PAR_FIRST;
                        state_next = ST_RT_START;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_RT_START:
            begin
                isq_start  = 1'b1;
                state_next = ST_RT_WAIT;
            end
            ST_RT_WAIT:
            begin
                if (isq_stat.done)
                begin
                    if (sel_reg == SEL_CRS_FIRST || sel_reg == SEL_CRS_SECOND)
                    begin
                        crs_next = crs_reg + PAIR_W'(root);
                    end
                    else
                    begin
                        par_next = par_reg + PAIR_W'(root);
                    end
                    if (method_reg == METHOD_CROSS && sel_reg != SEL_CRS_SECOND)
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_RT_START;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dist_next      = (d_full > PAIR_W'(DIST_MAX)) ? DIST_MAX
                                                                  : d_full[DIST_W-1:0];
                    acc_ctrl.clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_PAR_FIRST;
            last_reg      <= 1'b0;
            method_reg    <= METHOD_HAPLOID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                method_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        par_reg  <= par_next;
        crs_reg  <= crs_next;
        dist_reg <= dist_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, dist_reg};

    // root unit only reports back while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        isq_stat.done |-> state_reg == ST_RT_WAIT)
        else $error("root done outside wait state");

    // no new locus is taken while the root unit is running
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !isq_stat.busy)
        else $error("input ready while root unit busy");

    // a start always launches the root unit
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RT_START |=> isq_stat.busy)
        else $error("root unit did not start");

    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg <= SEL_MEAN_DIFF)
        else $error("sum selector out of range");

endmodule
